@@ src/mwrms_pkg.sv @@
// ----------------------------------------------------------------------------
// mwrms_pkg - shared types and constants of the moving window RMS block
// Controller states, controller-to-datapath commands, datapath status and
// the fixed field widths of the sample path.
// ----------------------------------------------------------------------------
package mwrms_pkg;

	// fixed widths of the sample path
	localparam int SAMPLE_W  = 12;
	localparam int CHAN_W    = 2;
	localparam int SUM_W     = 31;
	localparam int SQ_W      = 2 * SAMPLE_W;
	localparam int RMS_W     = 16;
	localparam int BIT_IDX_W = 4;
	localparam int FRAC_SH   = 8;

	// controller states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_SQ   = 6'b000100,
		ST_UPD  = 6'b001000,
		ST_ROOT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic cap;       // capture the accepted item
		logic rd;        // read the slot about to be replaced
		logic sq;        // register both squares
		logic upd;       // update sum, ring and position, start root
		logic root;      // one bit of the square root
		logic out_load;  // load the result register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic chan_ok;    // channel of the offered item is in range
		logic root_last;  // root is on its final bit
		logic out_free;   // result register can take a new item
	} status_t;

endpackage

@@ src/mwrms_ram.sv @@
// ----------------------------------------------------------------------------
// mwrms_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module mwrms_ram #(
	parameter int WIDTH  = 12,
	parameter int DEPTH  = 384,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/mwrms_ctrl.sv @@
// ----------------------------------------------------------------------------
// mwrms_ctrl - sequencer of the moving window RMS block
// Steps one item through read, square, update, sixteen root steps and
// result load, and holds off new items until the sequence is done.
// ----------------------------------------------------------------------------
module mwrms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mwrms_pkg::status_t  st,
	output mwrms_pkg::cmd_t     cmd
);

	mwrms_pkg::state_t state_q;
	mwrms_pkg::state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			mwrms_pkg::ST_IDLE: begin
				if (in_valid && st.chan_ok) begin
					cmd.cap = 1'b1;
					state_d = mwrms_pkg::ST_RD;
				end
			end
			mwrms_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = mwrms_pkg::ST_SQ;
			end
			mwrms_pkg::ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = mwrms_pkg::ST_UPD;
			end
			mwrms_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = mwrms_pkg::ST_ROOT;
			end
			mwrms_pkg::ST_ROOT: begin
				cmd.root = 1'b1;
				if (st.root_last) begin
					state_d = mwrms_pkg::ST_OUT;
				end
			end
			mwrms_pkg::ST_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mwrms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mwrms_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwrms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// out-of-range items are taken in idle and dropped
	assign in_stall = (state_q != mwrms_pkg::ST_IDLE);

endmodule

@@ src/mwrms_dp.sv @@
// ----------------------------------------------------------------------------
// mwrms_dp - datapath of the moving window RMS block
// Per-channel ring position, fill flag and sum of squares, the sample ring
// RAM, the squarers, a bit-per-cycle root scaled by the window length, and
// the result register.
// ----------------------------------------------------------------------------
module mwrms_dp #(
	parameter int WINDOW   = 100,
	parameter int CHANNELS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [mwrms_pkg::CHAN_W-1:0]        channel,
	input  logic [mwrms_pkg::SAMPLE_W-1:0]      sample,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [mwrms_pkg::CHAN_W-1:0]        channel_out,
	output logic [mwrms_pkg::RMS_W-1:0]         rms_value,
	input  mwrms_pkg::cmd_t                     cmd,
	output mwrms_pkg::status_t                  st
);

	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW     = $clog2(WINDOW);
	localparam int DEPTH  = CHANNELS << PW;
	localparam int AW     = $clog2(DEPTH);
	localparam int WW     = $clog2(WINDOW + 1);
	localparam int RWW    = mwrms_pkg::RMS_W + WW;
	localparam int CAND_W = 2 * mwrms_pkg::RMS_W + WW + 1;
	localparam int SW     = mwrms_pkg::SAMPLE_W;
	localparam int SUM_W  = mwrms_pkg::SUM_W;
	localparam int BW     = mwrms_pkg::BIT_IDX_W;

	localparam logic [PW-1:0]     POS_LAST = PW'(WINDOW - 1);
	localparam logic [CAND_W-1:0] WIN_C    = CAND_W'(WINDOW);
	localparam logic [RWW-1:0]    WIN_R    = RWW'(WINDOW);

	// per-channel state
	logic [PW-1:0]    pos_q  [CHANNELS];
	logic             wrap_q [CHANNELS];
	logic [SUM_W-1:0] sum_q  [CHANNELS];

	// item registers
	logic [CW-1:0]                  ch_q;
	logic [SW-1:0]                  smp_q;
	logic [mwrms_pkg::SQ_W-1:0]     sqo_q;
	logic [mwrms_pkg::SQ_W-1:0]     sqn_q;

	// root registers
	logic [mwrms_pkg::RMS_W-1:0]    r_q;
	logic [CAND_W-1:0]              r2w_q;
	logic [RWW-1:0]                 rw_q;
	logic [BW-1:0]                  bit_q;

	// result register
	logic                           out_valid_q;
	logic [mwrms_pkg::CHAN_W-1:0]   chout_q;
	logic [mwrms_pkg::RMS_W-1:0]    rms_q;

	logic [AW-1:0]    ram_addr;
	logic [SW-1:0]    ram_rd;
	logic [SW-1:0]    old_smp;
	logic [PW-1:0]    pos_cur;
	logic [SUM_W-1:0] sum_new;
	logic [CAND_W-1:0] tgt;
	logic [CAND_W-1:0] cand;
	logic [BW:0]       bit_p1;

	// item in range
	assign st.chan_ok   = (32'(channel) < CHANNELS);
	assign st.root_last = (bit_q == '0);
	assign st.out_free  = !out_valid_q || !out_stall;

	assign pos_cur  = pos_q[ch_q];
	assign ram_addr = AW'({ch_q, pos_cur});

	mwrms_ram #(
		.WIDTH  (SW),
		.DEPTH  (DEPTH),
		.ADDR_W (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (cmd.upd),
		.wr_addr (ram_addr),
		.wr_data (smp_q),
		.rd_en   (cmd.rd),
		.rd_addr (ram_addr),
		.rd_data (ram_rd)
	);

	// unwritten slots of a ring not yet filled read as zero
	assign old_smp = wrap_q[ch_q] ? ram_rd : '0;

	// capture item and squares
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ch_q  <= CW'(channel);
			smp_q <= sample;
		end
		if (cmd.sq) begin
			sqo_q <= old_smp * old_smp;
			sqn_q <= smp_q * smp_q;
		end
	end

	// replace oldest square, modulo 2^31
	assign sum_new = sum_q[ch_q] - SUM_W'(sqo_q) + SUM_W'(sqn_q);

	// advance ring position, track fill, update sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]  <= '0;
				wrap_q[i] <= 1'b0;
				sum_q[i]  <= '0;
			end
		end else if (cmd.upd) begin
			sum_q[ch_q] <= sum_new;
			if (pos_cur == POS_LAST) begin
				pos_q[ch_q]  <= '0;
				wrap_q[ch_q] <= 1'b1;
			end else begin
				pos_q[ch_q] <= pos_cur + PW'(1);
			end
		end
	end

	// trial square times window: r2w + (rw << (b+1)) + (W << 2b)
	assign bit_p1 = {1'b0, bit_q} + (BW + 1)'(1);
	assign tgt    = CAND_W'({sum_q[ch_q], {mwrms_pkg::FRAC_SH{1'b0}}});
	assign cand   = r2w_q + (CAND_W'(rw_q) << bit_p1) + (WIN_C << {bit_q, 1'b0});

	// root, one bit a cycle from the top
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			r_q   <= '0;
			r2w_q <= '0;
			rw_q  <= '0;
			bit_q <= BW'(mwrms_pkg::RMS_W - 1);
		end else if (cmd.root) begin
			if (cand <= tgt) begin
				r_q   <= r_q | (mwrms_pkg::RMS_W'(1) << bit_q);
				r2w_q <= cand;
				rw_q  <= rw_q + (WIN_R << bit_q);
			end
			bit_q <= bit_q - BW'(1);
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			chout_q <= mwrms_pkg::CHAN_W'(ch_q);
			rms_q   <= r_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = chout_q;
	assign rms_value   = rms_q;

endmodule

@@ src/moving_window_rms_core.sv @@
// An accepted item steps through read, square, update, root and result load in turn.
// No new item is taken before the last result is loaded; a stalled result delays this.
// The square root takes one bit a cycle and is the longest step of the sequence.
// Items with a channel outside the configured range are taken while idle and dropped.
// Reset clears sums, ring positions and fill flags at once; the ring RAM is not
// swept, as fill flags make unwritten slots read as zero.
// ----------------------------------------------------------------------------
// moving_window_rms_core - per-channel sliding window RMS of 12-bit samples
// Keeps the last WINDOW samples of each channel and reports the window RMS
// in unsigned Q12.4 for each accepted sample with a channel in range.
// ----------------------------------------------------------------------------
module moving_window_rms_core #(
	parameter int WINDOW   = 100,
	parameter int CHANNELS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mwrms_pkg::CHAN_W-1:0]    channel,
	input  logic [mwrms_pkg::SAMPLE_W-1:0]  sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mwrms_pkg::CHAN_W-1:0]    channel_out,
	output logic [mwrms_pkg::RMS_W-1:0]     rms_value
);

	mwrms_pkg::cmd_t    cmd;
	mwrms_pkg::status_t st;

	// sequencer
	mwrms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	mwrms_dp #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.channel     (channel),
		.sample      (sample),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.channel_out (channel_out),
		.rms_value   (rms_value),
		.cmd         (cmd),
		.st          (st)
	);

endmodule

@@ src/mwrms_checker.sv @@
// ----------------------------------------------------------------------------
// mwrms_checker - port-level checks of the moving window RMS block
// Watches input and output sides of the top level and flags handshake and range slips.
// ----------------------------------------------------------------------------
module mwrms_checker #(
	parameter int CHANNELS = 3
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [mwrms_pkg::CHAN_W-1:0]    channel,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [mwrms_pkg::CHAN_W-1:0]    channel_out,
	input logic [mwrms_pkg::RMS_W-1:0]     rms_value
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel_out) && $stable(rms_value))
		else $error("stalled result dropped or changed");

	// an in-range item starts a busy sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (32'(channel) < CHANNELS) |=> in_stall)
		else $error("block not busy after taking an item");

	// reported channel is always in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(channel_out) < CHANNELS))
		else $error("result channel out of range");

	// Q12.4 root of a 12-bit sample stays within full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rms_value <= 16'd65520))
		else $error("rms value above full scale");

endmodule

bind moving_window_rms_core mwrms_checker #(.CHANNELS(CHANNELS)) u_mwrms_checker (.*);

@@ verif/moving_window_rms_core_tb.sv @@
// ----------------------------------------------------------------------------
// moving_window_rms_core_tb - self-checking bench for the sliding window RMS
// A queue of samples feeds a clocked driver; a clocked monitor compares each
// reported channel and RMS with a behavioural model of the per-channel rings
// and sums of squares. Directed extremes come first, then random samples
// under four handshake pressure phases, with full-scale and zero bursts.
// ----------------------------------------------------------------------------
module moving_window_rms_core_tb;

	localparam int WINDOW      = 100;
	localparam int CHANNELS    = 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1250;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [mwrms_pkg::CHAN_W-1:0]   chan;
		logic [mwrms_pkg::SAMPLE_W-1:0] smp;
		int                             idle_pct;
		int                             stall_pct;
		bit                             drain;
	} sample_item_t;

	typedef struct {
		logic [mwrms_pkg::CHAN_W-1:0] chan;
		logic [mwrms_pkg::RMS_W-1:0]  rms;
	} rms_result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic [mwrms_pkg::CHAN_W-1:0]   channel   = '0;
	logic [mwrms_pkg::SAMPLE_W-1:0] sample    = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [mwrms_pkg::CHAN_W-1:0]   channel_out;
	logic [mwrms_pkg::RMS_W-1:0]    rms_value;

	sample_item_t pending_samples[$];
	rms_result_t  rms_expected[$];
	sample_item_t head_item;
	rms_result_t  got_rms;

	// model state of the windows
	logic [mwrms_pkg::SAMPLE_W-1:0] win_ring[CHANNELS][WINDOW];
	int                             win_pos[CHANNELS];
	logic [mwrms_pkg::SUM_W-1:0]    win_sum[CHANNELS];

	int recv_stall_pct = 0;
	int phase_idle     = 0;
	int phase_stall    = 0;
	bit phase_drain    = 1'b0;
	int mismatches     = 0;
	int cycle_count    = 0;
	int in_range_count = 0;

	moving_window_rms_core #(
		.WINDOW  (WINDOW),
		.CHANNELS(CHANNELS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel_out(channel_out),
		.rms_value  (rms_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// advance the window of one channel and queue the RMS it should report
	function automatic void predict_rms(input logic [mwrms_pkg::CHAN_W-1:0] ch,
			input logic [mwrms_pkg::SAMPLE_W-1:0] smp);
		logic [mwrms_pkg::SAMPLE_W-1:0] old_smp;
		logic [63:0]                    mean_sq;
		logic [15:0]                    root;
		logic [15:0]                    trial;
		rms_result_t                    res;
		if (ch >= CHANNELS)
			return;
		old_smp = win_ring[ch][win_pos[ch]];
		win_ring[ch][win_pos[ch]] = smp;
		win_sum[ch] = mwrms_pkg::SUM_W'(32'(win_sum[ch]) - 32'(old_smp) * 32'(old_smp)
				+ 32'(smp) * 32'(smp));
		win_pos[ch] = (win_pos[ch] == WINDOW - 1) ? 0 : win_pos[ch] + 1;
		mean_sq = (64'(win_sum[ch]) << mwrms_pkg::FRAC_SH) / 64'(WINDOW);
		// floor of the root, one bit at a time from the top
		root = '0;
		for (int b = mwrms_pkg::RMS_W - 1; b >= 0; b--) begin
			trial = root | (16'd1 << b);
			if (64'(trial) * 64'(trial) <= mean_sq)
				root = trial;
		end
		res.chan = ch;
		res.rms  = root;
		rms_expected.push_back(res);
	endfunction

	// hold the next item back for idling or for a full drain
	function automatic bit launch_allowed();
		if (pending_samples[0].drain && rms_expected.size() != 0)
			return 1'b0;
		return $urandom_range(99) >= pending_samples[0].idle_pct;
	endfunction

	function automatic logic [mwrms_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return mwrms_pkg::SAMPLE_W'($urandom_range(15));
			default: return mwrms_pkg::SAMPLE_W'($urandom_range(4095));
		endcase
	endfunction

	task automatic queue_sample(input logic [mwrms_pkg::CHAN_W-1:0] ch,
			input logic [mwrms_pkg::SAMPLE_W-1:0] smp);
		sample_item_t it;
		it.chan      = ch;
		it.smp       = smp;
		it.idle_pct  = phase_idle;
		it.stall_pct = phase_stall;
		it.drain     = phase_drain;
		phase_drain  = 1'b0;
		pending_samples.push_back(it);
		if (ch < CHANNELS)
			in_range_count++;
	endtask

	// driver: predict on acceptance, then present the next queued item
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_rms(channel, sample);
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() != 0 && launch_allowed()) begin
					head_item = pending_samples.pop_front();
					in_valid       <= 1'b1;
					channel        <= head_item.chan;
					sample         <= head_item.smp;
					recv_stall_pct <= head_item.stall_pct;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result taken, then pick the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (rms_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: channel %0d rms %0d",
								channel_out, rms_value);
				end else begin
					got_rms = rms_expected.pop_front();
					if (channel_out !== got_rms.chan || rms_value !== got_rms.rms) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: channel exp %0d got %0d, rms exp %0d got %0d",
									got_rms.chan, channel_out, got_rms.rms, rms_value);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int idle_set[4];
		int stall_set[4];
		int phase_end;
		logic [mwrms_pkg::CHAN_W-1:0] rnd_chan;

		idle_set  = '{0, 67, 0, 6};
		stall_set = '{0, 0, 67, 6};
		for (int c = 0; c < CHANNELS; c++) begin
			win_pos[c] = 0;
			win_sum[c] = '0;
			for (int k = 0; k < WINDOW; k++)
				win_ring[c][k] = '0;
		end

		// directed: extremes on an empty window, ignored channel, bit patterns
		queue_sample(2'd0, 12'hFFF);
		queue_sample(2'd1, 12'h000);
		queue_sample(2'd2, 12'hFFF);
		queue_sample(2'd0, 12'h000);
		queue_sample(2'd3, 12'hFFF);
		queue_sample(2'd3, 12'h000);
		queue_sample(2'd1, 12'hAAA);
		queue_sample(2'd2, 12'h555);
		queue_sample(2'd0, 12'h001);
		queue_sample(2'd1, 12'h800);
		queue_sample(2'd2, 12'h7FF);
		queue_sample(2'd0, 12'hFFF);
		queue_sample(2'd1, 12'hFFF);
		queue_sample(2'd2, 12'h000);
		phase_drain = 1'b1;
		queue_sample(2'd0, 12'h010);
		queue_sample(2'd2, 12'h001);

		// random phases, each opened by a full drain
		for (int p = 0; p < 4; p++) begin
			phase_idle  = idle_set[p];
			phase_stall = stall_set[p];
			phase_drain = 1'b1;
			phase_end   = 16 + (p + 1) * (ITEM_TARGET - 16) / 4;
			// drive one window to full scale, later back to zero
			if (p == 0 || p == 2)
				for (int k = 0; k < WINDOW + 10; k++) begin
					queue_sample(2'd1, (p == 0) ? 12'hFFF : 12'h000);
					if (k % 8 == 0)
						queue_sample(2'(k % 3 == 0 ? 0 : 2), random_sample());
				end
			while (in_range_count < phase_end) begin
				rnd_chan = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(CHANNELS - 1));
				queue_sample(rnd_chan, random_sample());
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() != 0 || in_valid)
			@(posedge clk);
		while (rms_expected.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (mismatches == 0 && rms_expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
